// ----- rtl/utf8cp_pkg.sv -----
// Shared types and constants for the UTF-8 code point lookup core.
`default_nettype none
package utf8cp_pkg;

    localparam int BYTE_W = 8;
    localparam int TGT_W  = 16;
    localparam int ACC_W  = 21;
    localparam int CP_W   = 22;
    localparam int CONT_W = 6;

    localparam logic [CP_W-1:0] CP_NOT_FOUND = {CP_W{1'b1}};

    typedef struct packed {
        logic            emit;
        logic            found;
        logic [CP_W-1:0] cp_value;
    } t_step_out;

endpackage
`default_nettype wire

// ----- rtl/utf8cp_decode.sv -----
// Per-byte sequence decoder with string state and code point position counter.
`default_nettype none
module utf8cp_decode
    import utf8cp_pkg::*;
#(
    parameter int INDEX_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic [TGT_W-1:0]  i_target_index,
    output t_step_out              o_step
);

    localparam int CMP_W = (INDEX_BITS > TGT_W) ? INDEX_BITS : TGT_W;

    logic [1:0]            r_rem, n_rem;
    logic [ACC_W-1:0]      r_acc, n_acc;
    logic [INDEX_BITS-1:0] r_cnt, n_cnt;
    logic                  r_ans, n_ans;
    logic                  finish;
    t_step_out             step;

    always_comb begin
        n_rem         = r_rem;
        n_acc         = r_acc;
        n_cnt         = r_cnt;
        n_ans         = r_ans;
        finish        = 1'b0;
        step.emit     = 1'b0;
        step.found    = 1'b0;
        step.cp_value = CP_NOT_FOUND;

        if (i_data_byte == '0) begin
            step.emit = !r_ans;
            n_rem     = '0;
            n_acc     = '0;
            n_cnt     = '0;
            n_ans     = 1'b0;
        end else if (r_rem != '0) begin
            n_acc  = {r_acc[ACC_W-CONT_W-1:0], i_data_byte[CONT_W-1:0]};
            n_rem  = r_rem - 2'd1;
            finish = (r_rem == 2'd1);
        end else begin
            case (i_data_byte) inside
                8'b0???????: begin
                    n_acc  = ACC_W'(i_data_byte);
                    finish = 1'b1;
                end
                8'b110?????: begin
                    n_acc = ACC_W'(i_data_byte[4:0]);
                    n_rem = 2'd1;
                end
                8'b1110????: begin
                    n_acc = ACC_W'(i_data_byte[3:0]);
                    n_rem = 2'd2;
                end
                8'b11110???: begin
                    n_acc = ACC_W'(i_data_byte[2:0]);
                    n_rem = 2'd3;
                end
                default: begin
                    n_acc  = ACC_W'(i_data_byte[6:0]);
                    finish = 1'b1;
                end
            endcase
        end

        if (finish) begin
            if (!r_ans && ((CMP_W)'(r_cnt) == (CMP_W)'(i_target_index))) begin
                step.emit     = 1'b1;
                step.found    = 1'b1;
                step.cp_value = {1'b0, n_acc};
                n_ans         = 1'b1;
            end
            if (r_cnt != '1) begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_acc <= '0;
            r_cnt <= '0;
            r_ans <= 1'b0;
        end else if (i_advance) begin
            r_rem <= n_rem;
            r_acc <= n_acc;
            r_cnt <= n_cnt;
            r_ans <= n_ans;
        end
    end

    assign o_step = step;

    a_emit_sets_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && step.emit && (i_data_byte != '0) |=> r_ans)
        else $error("answered flag not set after a found result");

    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && (i_data_byte == '0) |=> (r_rem == '0) && (r_cnt == '0) && !r_ans)
        else $error("string state not cleared by terminator");

    a_single_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step.emit |-> !r_ans)
        else $error("second result for one string");

    a_not_found_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step.emit && !step.found |-> (step.cp_value == CP_NOT_FOUND))
        else $error("not-found result without all-ones code point");

endmodule
`default_nettype wire

// ----- rtl/utf8cp_out.sv -----
// Result register between the decoder and the output channel.
`default_nettype none
module utf8cp_out
    import utf8cp_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire t_step_out       i_step,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_free,
    output logic                 o_found,
    output logic [CP_W-1:0]      o_cp_value
);

    logic            r_valid, n_valid;
    logic            r_found;
    logic [CP_W-1:0] r_cp;

    assign o_free  = !r_valid || i_out_ready;
    assign n_valid = (i_load && i_step.emit) || (r_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_step.emit) begin
            r_found <= i_step.found;
            r_cp    <= i_step.cp_value;
        end
    end

    assign o_out_valid = r_valid;
    assign o_found     = r_found;
    assign o_cp_value  = r_cp;

endmodule
`default_nettype wire

// ----- rtl/utf8_code_point_at_index_core.sv -----
// Top level of the UTF-8 code point lookup core.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  input   | in        | i_in_valid / o_in_ready| i_data_byte[7:0]
//  output  | out       | o_out_valid/i_out_ready| o_found, o_cp_value[21:0]
//  config  | in        | i_cfg_we               | i_cfg_wdata[15:0]
//
// One byte per cycle sustained while the result register drains; each input
// transaction passes the input register, decoder and result register in turn.
// Synchronous active-low reset clears target index, string state and valids.
// A stalled result holds the result register; the input register keeps
// accepting while it can drain, and stalls only when both registers are full.
`default_nettype none
module utf8_code_point_at_index_core
    import utf8cp_pkg::*;
#(
    parameter int INDEX_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_found,
    output logic [CP_W-1:0]        o_cp_value,
    input  wire logic              i_cfg_we,
    input  wire logic [TGT_W-1:0]  i_cfg_wdata
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic [TGT_W-1:0]  r_target;
    logic              out_free;
    logic              advance;
    t_step_out         step;

    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_target   <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_we) begin
                r_target <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    utf8cp_decode #(
        .INDEX_BITS (INDEX_BITS)
    ) u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_data_byte    (r_in_byte),
        .i_target_index (r_target),
        .o_step         (step)
    );

    utf8cp_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (advance),
        .i_step       (step),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_free       (out_free),
        .o_found      (o_found),
        .o_cp_value   (o_cp_value)
    );

endmodule
`default_nettype wire
